// File: hw/rtl/ibiaq_pkg.sv
// Package for the interbeat interval artifact qualifier.
// Holds widths, window size, register indexes, reset values and shared structs.
// No dependencies.
`default_nettype none

package ibiaq_pkg;

    // window of accepted intervals
    localparam int WINDOW    = 8;
    localparam int SLOT_W    = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // field widths
    localparam int IBI_W     = 16;
    localparam int PCT_W     = 7;
    localparam int SUM_W     = IBI_W + SLOT_W;
    localparam int PROD_W    = IBI_W + PCT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // percent scale for the relative band
    localparam int PCT_SCALE = 100;

    // configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ABS_MIN   = 2'd0,
        CFG_ABS_MAX   = 2'd1,
        CFG_PCT_BELOW = 2'd2,
        CFG_PCT_ABOVE = 2'd3
    } t_cfg_idx;

    // register reset values
    localparam logic [IBI_W-1:0] ABS_MIN_RST   = IBI_W'(300);
    localparam logic [IBI_W-1:0] ABS_MAX_RST   = IBI_W'(2000);
    localparam logic [PCT_W-1:0] PCT_BELOW_RST = PCT_W'(30);
    localparam logic [PCT_W-1:0] PCT_ABOVE_RST = PCT_W'(30);

    // live configuration handed to the qualifier core
    typedef struct packed {
        logic [IBI_W-1:0] abs_min_ms;
        logic [IBI_W-1:0] abs_max_ms;
        logic [PCT_W-1:0] pct_below;
        logic [PCT_W-1:0] pct_above;
    } t_cfg;

    // one result item
    typedef struct packed {
        logic             is_artifact;
        logic             used_average;
        logic [IBI_W-1:0] mean_ms;
    } t_verdict;

endpackage

`default_nettype wire

// File: hw/rtl/ibiaq_if.sv
// Valid/ready channel interfaces of the interbeat interval artifact qualifier.
// Depends on ibiaq_pkg for field widths.
`default_nettype none

// interval input channel
interface ibiaq_in_if;
    import ibiaq_pkg::*;
    logic             valid;
    logic             ready;
    logic [IBI_W-1:0] interval_ms;

    modport source (output valid, output interval_ms, input ready);
    modport sink   (input valid, input interval_ms, output ready);
endinterface

// result channel
interface ibiaq_out_if;
    import ibiaq_pkg::*;
    logic             valid;
    logic             ready;
    logic             is_artifact;
    logic             used_average;
    logic [IBI_W-1:0] mean_ms;

    modport source (output valid, output is_artifact, output used_average,
                    output mean_ms, input ready);
    modport sink   (input valid, input is_artifact, input used_average,
                    input mean_ms, output ready);
endinterface

// configuration write channel
interface ibiaq_cfg_if;
    import ibiaq_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [CFG_DAT_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/ibiaq_core.sv
// Qualifier core: window store, running sum, ring slot and the accept decision.
// Depends on ibiaq_pkg. The verdict is combinational from the current item and state;
// state advances on i_step when the item is accepted.
`default_nettype none

module ibiaq_core (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_step,
    input  wire  [ibiaq_pkg::IBI_W-1:0]    i_ibi,
    input  wire  ibiaq_pkg::t_cfg          i_cfg,
    output ibiaq_pkg::t_verdict            o_verdict
);
    import ibiaq_pkg::*;

    // window state
    logic [IBI_W-1:0]  r_store [WINDOW];
    logic [SUM_W-1:0]  r_sum;
    logic [SLOT_W-1:0] r_slot;
    logic              r_full;

    logic [SUM_W-1:0]  n_sum;
    logic [SLOT_W-1:0] n_slot;
    logic              n_full;

    logic [IBI_W-1:0]  mean;
    logic [IBI_W-1:0]  oldest;
    logic [IBI_W-1:0]  dev;
    logic [PROD_W-1:0] dev_scaled;
    logic [PROD_W-1:0] lo_margin;
    logic [PROD_W-1:0] hi_margin;
    logic              below;
    logic              above;
    logic              artifact;
    logic              last_slot;

    assign mean      = IBI_W'(r_sum / WINDOW);
    assign oldest    = r_store[r_slot];
    assign last_slot = (r_slot == SLOT_W'(WINDOW - 1));

    // relative band without dividing: x < mean - floor(p*mean/100)
    // holds exactly when 100*(mean - x) > p*mean, and likewise above
    assign dev        = (i_ibi < mean) ? (mean - i_ibi) : (i_ibi - mean);
    assign dev_scaled = PROD_W'(dev) * PROD_W'(PCT_SCALE);
    assign lo_margin  = PROD_W'(i_cfg.pct_below) * PROD_W'(mean);
    assign hi_margin  = PROD_W'(i_cfg.pct_above) * PROD_W'(mean);
    assign below      = (i_ibi < mean) && (dev_scaled > lo_margin);
    assign above      = (i_ibi > mean) && (dev_scaled > hi_margin);

    // decision: absolute limits while filling, relative band once full
    always_comb begin
        if (r_full) begin
            artifact = below || above;
        end else begin
            artifact = (i_ibi < i_cfg.abs_min_ms) || (i_ibi > i_cfg.abs_max_ms);
        end
    end

    assign o_verdict.is_artifact  = artifact;
    assign o_verdict.used_average = r_full;
    assign o_verdict.mean_ms      = r_full ? mean : '0;

    // next window state on an accepted interval
    always_comb begin
        n_sum  = r_sum;
        n_slot = r_slot;
        n_full = r_full;
        if (i_step && !artifact) begin
            n_sum  = r_sum - (r_full ? SUM_W'(oldest) : '0) + SUM_W'(i_ibi);
            n_slot = last_slot ? '0 : r_slot + 1'b1;
            if (last_slot) begin
                n_full = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_slot <= '0;
            r_full <= 1'b0;
        end else begin
            r_sum  <= n_sum;
            r_slot <= n_slot;
            r_full <= n_full;
        end
    end

    // window entries: written in ring order, read only once written
    always_ff @(posedge i_clk) begin
        if (i_step && !artifact) begin
            r_store[r_slot] <= i_ibi;
        end
    end

    // a full window never empties again
    a_full_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_full |=> r_full)
        else $error("window full flag dropped");

    // a rejected interval leaves the window untouched
    a_reject_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && artifact) |=> ($stable(r_sum) && $stable(r_slot)))
        else $error("rejected interval changed the window");

    // an accepted interval advances the ring by one
    a_slot_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && !artifact && !last_slot) |=> (r_slot == $past(r_slot) + 1'b1))
        else $error("ring slot did not advance");

    // while filling, the mean is reported as zero
    a_fill_mean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_full |-> (!o_verdict.used_average && (o_verdict.mean_ms == '0)))
        else $error("mean reported while window fills");

endmodule

`default_nettype wire

// File: hw/rtl/ibi_artifact_qualifier.sv
// Interbeat interval artifact qualifier, top level.
// Each interval is held in an input register and moves into the result register
// when that is free or drains. Throughput: one interval per cycle while the result
// side does not stall; the window sum, ring slot and decision update as an item
// moves from the input register into the result register.
// Reset (synchronous, active low): window empty, sum and slot zero, registers to defaults.
`default_nettype none

module ibi_artifact_qualifier (
    input  wire          i_clk,
    input  wire          i_rst_n,
    ibiaq_in_if.sink     i_in,
    ibiaq_out_if.source  o_out,
    ibiaq_cfg_if.sink    i_cfg
);
    import ibiaq_pkg::*;

    t_cfg             r_cfg;
    logic             r_in_valid;
    logic [IBI_W-1:0] r_in_ibi;
    logic             r_out_valid;
    t_verdict         r_out;
    t_verdict         verdict;
    logic             advance;

    // configuration registers; writes are always taken
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.abs_min_ms <= ABS_MIN_RST;
            r_cfg.abs_max_ms <= ABS_MAX_RST;
            r_cfg.pct_below  <= PCT_BELOW_RST;
            r_cfg.pct_above  <= PCT_ABOVE_RST;
        end else if (i_cfg.valid) begin
            unique case (t_cfg_idx'(i_cfg.index))
                CFG_ABS_MIN:   r_cfg.abs_min_ms <= IBI_W'(i_cfg.data);
                CFG_ABS_MAX:   r_cfg.abs_max_ms <= IBI_W'(i_cfg.data);
                CFG_PCT_BELOW: r_cfg.pct_below  <= i_cfg.data[PCT_W-1:0];
                CFG_PCT_ABOVE: r_cfg.pct_above  <= i_cfg.data[PCT_W-1:0];
                default: ;
            endcase
        end
    end

    // input register moves into the result register when that is free or drains
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_ibi <= i_in.interval_ms;
        end
    end

    ibiaq_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_step    (advance),
        .i_ibi     (r_in_ibi),
        .i_cfg     (r_cfg),
        .o_verdict (verdict)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= verdict;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.is_artifact  = r_out.is_artifact;
    assign o_out.used_average = r_out.used_average;
    assign o_out.mean_ms      = r_out.mean_ms;

endmodule

`default_nettype wire

// File: tb/ibi_artifact_qualifier_tb.sv
// Self-checking testbench for the interbeat interval artifact qualifier.
// Needs ibiaq_pkg, the channel interfaces of ibiaq_if.sv and ibi_artifact_qualifier.
// Directed stimulus table first, then randomized phases checked against a predictor.
`default_nettype none

module ibi_artifact_qualifier_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ibiaq_pkg::*;

    localparam int RANDOM_ITEMS = 1650;
    localparam int STEADY_TAIL  = 200;
    localparam int IDLE_LIMIT   = 1000;
    localparam int MAX_REPORTS  = 10;

    // kinds of rows in the directed table
    typedef enum logic [1:0] {
        ROW_ITEM,
        ROW_REG,
        ROW_NEAR_MEAN
    } t_row_kind;

    typedef struct {
        t_row_kind        kind;
        t_cfg_idx         reg_idx;
        logic [IBI_W-1:0] value;
        int               offset;
        bit               typed;
        bit               artifact;
    } t_stim_row;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    ibiaq_in_if  in_ch ();
    ibiaq_out_if out_ch ();
    ibiaq_cfg_if cfg_ch ();

    ibi_artifact_qualifier i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #2 i_clk = ~i_clk;

    // predictor copy of the registers and the window
    logic [IBI_W-1:0]  lim_min = ABS_MIN_RST;
    logic [IBI_W-1:0]  lim_max = ABS_MAX_RST;
    logic [PCT_W-1:0]  pct_lo  = PCT_BELOW_RST;
    logic [PCT_W-1:0]  pct_hi  = PCT_ABOVE_RST;
    logic [IBI_W-1:0]  ring [WINDOW];
    logic [SLOT_W:0]   fill   = '0;
    int                oldest = 0;
    logic [SUM_W-1:0]  sum    = '0;

    t_verdict   pending_verdicts [$];
    t_verdict   typed_verdict = '0;
    bit         row_typed = 1'b0;
    t_verdict   predicted;
    t_verdict   got;
    t_verdict   want;

    bit          calm   = 1'b0;
    bit          steady = 1'b0;
    int          stall_left = 0;
    int unsigned idle_cycles = 0;
    int unsigned mismatches = 0;
    int unsigned items_in = 0;
    int unsigned results_seen = 0;
    int unsigned artifacts_seen = 0;
    int unsigned averaged_seen = 0;
    int unsigned reg_writes = 0;

    // mean of the window and the relative band around it
    function automatic void band_limits(output longint lo, output longint hi,
                                        output longint m);
        longint pb;
        longint pa;
        m  = sum / WINDOW;
        pb = pct_lo;
        pa = pct_hi;
        lo = m - (pb * m) / PCT_SCALE;
        hi = m + (pa * m) / PCT_SCALE;
    endfunction

    // verdict for one interval, updating the window when it is accepted
    function automatic t_verdict qualify_interval(logic [IBI_W-1:0] ibi);
        t_verdict v;
        longint   x;
        longint   lo;
        longint   hi;
        longint   m;
        v = '0;
        x = ibi;
        if (fill < WINDOW) begin
            if (ibi < lim_min || ibi > lim_max) begin
                v.is_artifact = 1'b1;
            end else begin
                ring[fill[SLOT_W-1:0]] = ibi;
                sum  = sum + ibi;
                fill = fill + 1'b1;
            end
        end else begin
            band_limits(lo, hi, m);
            v.used_average = 1'b1;
            v.mean_ms      = m[IBI_W-1:0];
            if (x < lo || x > hi) begin
                v.is_artifact = 1'b1;
            end else begin
                sum          = sum - ring[oldest] + ibi;
                ring[oldest] = ibi;
                oldest       = (oldest + 1) % WINDOW;
            end
        end
        return v;
    endfunction

    function automatic logic [IBI_W-1:0] clamp_ibi(longint v);
        if (v < 0) return '0;
        if (v > 65535) return '1;
        return v[IBI_W-1:0];
    endfunction

    function automatic t_stim_row item_row(logic [IBI_W-1:0] v, bit typed = 1'b0,
                                           bit artifact = 1'b0);
        t_stim_row r;
        r = '{ROW_ITEM, CFG_ABS_MIN, v, 0, typed, artifact};
        return r;
    endfunction

    function automatic t_stim_row reg_row(t_cfg_idx idx, logic [IBI_W-1:0] d);
        t_stim_row r;
        r = '{ROW_REG, idx, d, 0, 1'b0, 1'b0};
        return r;
    endfunction

    function automatic t_stim_row near_row(int off);
        t_stim_row r;
        r = '{ROW_NEAR_MEAN, CFG_ABS_MIN, '0, off, 1'b0, 1'b0};
        return r;
    endfunction

    // drive one interval and hold it until the transfer; called at a falling edge
    task automatic push_interval(logic [IBI_W-1:0] v, bit typed, bit artifact);
        if (!calm && !steady && $urandom_range(0, 5) == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge i_clk);
        end
        row_typed     = typed;
        typed_verdict = '{is_artifact: artifact, used_average: 1'b0, mean_ms: '0};
        in_ch.interval_ms = v;
        in_ch.valid       = 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(t_cfg_idx idx, logic [CFG_DAT_W-1:0] d);
        cfg_ch.index = idx;
        cfg_ch.data  = d;
        cfg_ch.valid = 1'b1;
        @(posedge i_clk);
        while (!cfg_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        cfg_ch.valid = 1'b0;
    endtask

    // stop sending and let every outstanding result arrive
    task automatic wait_drain();
        in_ch.valid = 1'b0;
        while (pending_verdicts.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // result side: random stall bursts, none in calm or steady stretches
    always @(negedge i_clk) begin
        if (calm || steady) begin
            out_ch.ready = 1'b1;
        end else if (stall_left != 0) begin
            stall_left   = stall_left - 1;
            out_ch.ready = 1'b0;
        end else if ($urandom_range(0, 9) == 0) begin
            stall_left   = $urandom_range(1, 15) - 1;
            out_ch.ready = 1'b0;
        end else begin
            out_ch.ready = 1'b1;
        end
    end

    // monitor: register writes, result checks, then predictions for new intervals
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                reg_writes++;
                case (t_cfg_idx'(cfg_ch.index))
                    CFG_ABS_MIN:   lim_min = cfg_ch.data;
                    CFG_ABS_MAX:   lim_max = cfg_ch.data;
                    CFG_PCT_BELOW: pct_lo  = cfg_ch.data[PCT_W-1:0];
                    CFG_PCT_ABOVE: pct_hi  = cfg_ch.data[PCT_W-1:0];
                    default: ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                got = '{out_ch.is_artifact, out_ch.used_average, out_ch.mean_ms};
                results_seen++;
                if (got.is_artifact) artifacts_seen++;
                if (got.used_average) averaged_seen++;
                if (pending_verdicts.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: result with nothing pending: art=%0b avg=%0b mean=%0d",
                                 $realtime, got.is_artifact, got.used_average, got.mean_ms);
                end else begin
                    want = pending_verdicts.pop_front();
                    if (got.is_artifact !== want.is_artifact ||
                        got.used_average !== want.used_average ||
                        got.mean_ms !== want.mean_ms) begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display({"%0t: result %0d mismatch: art exp %0b got %0b, ",
                                      "avg exp %0b got %0b, mean exp %0d got %0d"},
                                     $realtime, results_seen, want.is_artifact,
                                     got.is_artifact, want.used_average, got.used_average,
                                     want.mean_ms, got.mean_ms);
                    end
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                predicted = qualify_interval(in_ch.interval_ms);
                pending_verdicts.push_back(row_typed ? typed_verdict : predicted);
                items_in++;
            end
        end
    end

    // watchdog: too long without any transfer ends the run
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no transfer for %0d cycles, %0d results pending",
                     IDLE_LIMIT, pending_verdicts.size());
            $display("Simulation FAILED");
            $finish;
        end
    end

    // stimulus
    initial begin
        t_stim_row        directed_rows [$];
        longint           lo;
        longint           hi;
        longint           m;
        longint           span;
        longint           pick;
        int               sent;
        int               phase_len;
        int               kind;
        int               directed_count;
        logic [IBI_W-1:0] d;

        in_ch.valid       = 1'b0;
        in_ch.interval_ms = '0;
        out_ch.ready      = 1'b0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_ABS_MIN;
        cfg_ch.data       = '0;
        foreach (ring[k]) ring[k] = '0;

        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        // fill with default, inverted and widest absolute limits, then the band extremes
        directed_rows = '{
            item_row(16'd0, 1, 1), item_row(16'd65535, 1, 1),
            item_row(16'd299, 1, 1), item_row(16'd2001, 1, 1), item_row(16'd300, 1, 0),
            reg_row(CFG_ABS_MIN, 16'd2000), reg_row(CFG_ABS_MAX, 16'd300),
            item_row(16'd1000, 1, 1), item_row(16'd2000, 1, 1), item_row(16'd300, 1, 1),
            reg_row(CFG_ABS_MIN, 16'd0), reg_row(CFG_ABS_MAX, 16'd65535),
            item_row(16'd0, 1, 0), item_row(16'd65535, 1, 0),
            reg_row(CFG_ABS_MIN, 16'd300), reg_row(CFG_ABS_MAX, 16'd2000),
            item_row(16'd2000, 1, 0), item_row(16'd1000, 1, 0), item_row(16'd1000, 1, 0),
            item_row(16'd1000, 1, 0), item_row(16'd1000, 1, 0),
            item_row(16'd0), item_row(16'd65535),
            reg_row(CFG_PCT_BELOW, 16'd127), reg_row(CFG_PCT_ABOVE, 16'd127),
            item_row(16'd0), item_row(16'd65535),
            reg_row(CFG_PCT_BELOW, 16'd0), reg_row(CFG_PCT_ABOVE, 16'd0),
            near_row(0), near_row(1), near_row(-1),
            reg_row(CFG_PCT_BELOW, 16'd100), reg_row(CFG_PCT_ABOVE, 16'd100),
            item_row(16'd0), near_row(0)
        };

        foreach (directed_rows[k]) begin
            case (directed_rows[k].kind)
                ROW_REG: begin
                    wait_drain();
                    write_reg(directed_rows[k].reg_idx, directed_rows[k].value);
                end
                ROW_NEAR_MEAN: begin
                    band_limits(lo, hi, m);
                    push_interval(clamp_ibi(m + directed_rows[k].offset), 1'b0, 1'b0);
                end
                default: begin
                    push_interval(directed_rows[k].value, directed_rows[k].typed,
                                  directed_rows[k].artifact);
                end
            endcase
        end
        directed_count = items_in;
        row_typed = 1'b0;

        // random phases, each starting from an idle block with fresh settings
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            wait_drain();
            steady = (sent >= RANDOM_ITEMS - STEADY_TAIL);
            calm   = !steady && ($urandom_range(0, 3) == 0);
            for (int r = 0; r < 4; r++) begin
                if ($urandom_range(0, 1) == 1) begin
                    if (t_cfg_idx'(r) == CFG_ABS_MIN || t_cfg_idx'(r) == CFG_ABS_MAX) begin
                        d = IBI_W'($urandom_range(0, 65535));
                    end else begin
                        case ($urandom_range(0, 15))
                            0, 1:    d = 16'd0;
                            2, 3:    d = 16'd100;
                            4:       d = 16'd127;
                            default: d = IBI_W'($urandom_range(0, 100));
                        endcase
                    end
                    write_reg(t_cfg_idx'(r), d);
                end
            end
            if (steady) begin
                phase_len = RANDOM_ITEMS - sent;
            end else begin
                phase_len = $urandom_range(40, 160);
                if (sent + phase_len > RANDOM_ITEMS - STEADY_TAIL)
                    phase_len = RANDOM_ITEMS - STEADY_TAIL - sent;
            end
            repeat (phase_len) begin
                band_limits(lo, hi, m);
                kind = $urandom_range(0, 99);
                if (kind < 50) begin
                    // around the mean, a little wider than the band
                    span = (m * ((pct_lo > pct_hi ? pct_lo : pct_hi) + 10)) / PCT_SCALE;
                    if (span < 3) span = 3;
                    pick = m - span + longint'($urandom_range(0, 2 * span));
                end else if (kind < 65) begin
                    // on a band edge or one step to either side of it
                    pick = ($urandom_range(0, 1) ? lo : hi) + $urandom_range(0, 2) - 1;
                end else if (kind < 90) begin
                    pick = $urandom_range(0, 65535);
                end else begin
                    case ($urandom_range(0, 2))
                        0:       pick = 0;
                        1:       pick = 65535;
                        default: pick = m;
                    endcase
                end
                push_interval(clamp_ibi(pick), 1'b0, 1'b0);
                sent++;
            end
        end

        wait_drain();
        repeat (8) @(negedge i_clk);
        if (pending_verdicts.size() != 0) mismatches += pending_verdicts.size();

        $display("Ran %0d intervals (%0d from the directed table) over %0d register writes.",
                 items_in, directed_count, reg_writes);
        $display("%0d results checked: %0d artifacts, %0d judged by the window mean; %0d errors.",
                 results_seen, artifacts_seen, averaged_seen, mismatches);
        if (mismatches == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire

// File: filelist.f
hw/rtl/ibiaq_pkg.sv
hw/rtl/ibiaq_if.sv
hw/rtl/ibiaq_core.sv
hw/rtl/ibi_artifact_qualifier.sv
tb/ibi_artifact_qualifier_tb.sv
